[hdl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by the channel interfaces, the queue cell and the top level.
package spq_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int ST_W  = 2;

  // Request codes.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } spq_ent_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic     ins;
    logic     ext;
    spq_ent_t ent;
  } spq_op_t;

endpackage

[hdl/spq_in_if.sv]
// Request channel of the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_in_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [TAG_W-1:0] vertex_tag;
  logic [KEY_W-1:0] priority_key;

  modport source (output valid, req_type, vertex_tag, priority_key, input ready);
  modport sink   (input valid, req_type, vertex_tag, priority_key, output ready);
endinterface

[hdl/spq_out_if.sv]
// Result channel of the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_out_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] vertex_out;
  logic [ST_W-1:0]  status;
  logic             now_empty;

  modport source (output valid, vertex_out, status, now_empty, input ready);
  modport sink   (input valid, vertex_out, status, now_empty, output ready);
endinterface

[hdl/spq_cell.sv]
// One cell of the sorted row: holds one entry and updates from its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_op_t  op,
  input  logic              in_range,
  input  logic              left_stays,
  input  spq_pkg::spq_ent_t left_ent,
  input  spq_pkg::spq_ent_t right_ent,
  output spq_pkg::spq_ent_t ent,
  output logic              stays
);
  import spq_pkg::*;

  spq_ent_t ent_r;
  spq_ent_t ent_nxt;

  // A valid entry no greater than the new key keeps its place on insert.
  assign stays = in_range && (ent_r.key <= op.ent.key);

  // Insert shifts right behind the insertion point; extract shifts left.
  always_comb begin
    ent_nxt = ent_r;
    if (op.ins) begin
      if (!stays) begin
        ent_nxt = left_stays ? op.ent : left_ent;
      end
    end else if (op.ext) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

[hdl/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: a row of cells kept in key order.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------
//  in_chan  | in  | req_type, vertex_tag, priority_key
//  out_chan | out | vertex_out, status, now_empty
//
// One item is taken per cycle unless out_chan stalls; every cell compares and shifts in the same cycle.
// The result appears in the output register in the cycle after the item is taken.
// A new item is taken while the pending result is being taken in the same cycle.
// Reset clears the occupancy count and the output valid; entries are not cleared.
// No item is taken while reset is asserted.
module sorted_priority_queue_core #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    occ_r, occ_nxt;
  logic             out_valid_r;
  logic [TAG_W-1:0] vout_r, vout_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic             empty_r, empty_nxt;

  logic     acc, is_ins, full, empty;
  spq_op_t  op;
  spq_ent_t ents  [DEPTH];
  logic     stays [DEPTH];

  // Handshake and request decode.
  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign acc    = in_chan.valid && in_chan.ready;
  assign is_ins = (in_chan.req_type == REQ_INSERT);
  assign full   = (occ_r == CW'(DEPTH));
  assign empty  = (occ_r == '0);

  always_comb begin
    op.ins     = acc && is_ins && !full;
    op.ext     = acc && !is_ins && !empty;
    op.ent.key = in_chan.priority_key;
    op.ent.tag = in_chan.vertex_tag;
  end

  // Row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic     l_stays;
    spq_ent_t l_ent, r_ent;
    if (i == 0) begin : g_first
      assign l_stays = 1'b1;
      assign l_ent   = ents[0];
    end else begin : g_mid
      assign l_stays = stays[i-1];
      assign l_ent   = ents[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_ent = ents[i];
    end else begin : g_inner
      assign r_ent = ents[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .in_range   (occ_r > CW'(i)),
      .left_stays (l_stays),
      .left_ent   (l_ent),
      .right_ent  (r_ent),
      .ent        (ents[i]),
      .stays      (stays[i])
    );
  end

  // Occupancy and result for the item taken this cycle.
  always_comb begin
    occ_nxt  = occ_r;
    vout_nxt = '0;
    st_nxt   = ST_DONE;
    if (is_ins) begin
      if (full) begin
        st_nxt = ST_FULL;
      end else begin
        occ_nxt = occ_r + CW'(1);
      end
    end else begin
      if (empty) begin
        st_nxt = ST_EMPTY;
      end else begin
        occ_nxt  = occ_r - CW'(1);
        vout_nxt = ents[0].tag;
      end
    end
    empty_nxt = (occ_nxt == '0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        occ_r <= occ_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (acc) begin
      vout_r  <= vout_nxt;
      st_r    <= st_nxt;
      empty_r <= empty_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.vertex_out = vout_r;
  assign out_chan.status     = st_r;
  assign out_chan.now_empty  = empty_r;

  // The count never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above capacity");

  // A pending result reports emptiness in step with the count.
  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (empty_r == (occ_r == '0)))
    else $error("now_empty disagrees with occupancy");

  // An extract from an empty queue reports empty and leaves the count alone.
  a_ext_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !is_ins && empty) |=> (st_r == ST_EMPTY) && (occ_r == '0))
    else $error("extract on empty mishandled");

  // A refused insert leaves the queue full.
  a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_ins && full) |=> (st_r == ST_FULL) && (occ_r == CW'(DEPTH)))
    else $error("insert into full queue mishandled");

  // Every taken item yields a pending result.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("result lost");

endmodule
